// File: rtl/ihp_pkg.sv
// Shared types and constants for the indexed min-heap.
`default_nettype none
package ihp_pkg;

	localparam int CapacityDefault = 256;
	localparam int NumIds = 256;
	localparam int IdW = 8;
	localparam int PriW = 16;
	localparam int CmdW = 2;
	localparam int StatW = 2;
	localparam int EntryW = PriW + IdW;
	localparam int InDataW = ((IdW + PriW + 7) / 8) * 8;

	typedef struct packed {
		logic [PriW-1:0] pri;
		logic [IdW-1:0]  id;
	} entry_t;

	typedef enum logic [CmdW-1:0] {
		CMD_INSERT  = 2'd0,
		CMD_CHANGE  = 2'd1,
		CMD_EXTRACT = 2'd2,
		CMD_DELETE  = 2'd3
	} cmd_t;

	typedef enum logic [StatW-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_ABSENT = 2'd3
	} stat_t;

	typedef enum logic [2:0] {
		RD_NONE, RD_S, RD_PARENT, RD_LAST, RD_LEFT, RD_RIGHT
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE, WR_HELD, WR_RD, WR_CHILD
	} wr_sel_t;

	typedef enum logic [2:0] {
		S_KEEP, S_COUNT, S_ZERO, S_MAP, S_PARENT, S_CHILD
	} s_sel_t;

	typedef enum logic [1:0] {
		H_KEEP, H_REQ, H_RD
	} hold_sel_t;

	typedef enum logic [1:0] {
		CH_KEEP, CH_RD_LEFT, CH_PICK
	} child_sel_t;

	typedef struct packed {
		logic       in_ready;
		rd_sel_t    rd_sel;
		wr_sel_t    wr_sel;
		s_sel_t     s_sel;
		hold_sel_t  hold_sel;
		logic       load_left;
		child_sel_t child_sel;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       mark_start;
		logic       capture_out;
		logic       set_status;
		stat_t      status;
		logic       out_load;
	} ctl_t;

	typedef struct packed {
		logic accept;
		cmd_t cmd;
		logic present;
		logic full;
		logic empty;
		logic s_zero;
		logic parent_greater;
		logic at_start;
		logic s_below;
		logic l_in;
		logic r_in;
		logic child_less;
		logic pri_eq;
		logic pri_lt;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/ihp_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ihp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/ihp_ctrl.sv
// Controller state machine sequencing lookups, removals and sifts.
`default_nettype none
module ihp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  ihp_pkg::sts_t sts,
	output ihp_pkg::ctl_t ctl
);

	typedef enum logic [3:0] {
		IDLE, LOOK, CH_A, CH_B, RM_A, RM_B, RM_C,
		UP_RD, UP_CMP, DN_RD, DN_RL, DN_RR, DN_CMP, FIN
	} state_t;

	state_t state_q, state_d;
	logic   need_down_q, need_down_d;
	logic   down_after_up;

	// After a removal the moved element goes down only if sift-up left it in place.
	assign down_after_up = need_down_q && sts.at_start;

	always_comb begin
		state_d = state_q;
		need_down_d = need_down_q;
		ctl = '0;
		ctl.rd_sel = ihp_pkg::RD_NONE;
		ctl.wr_sel = ihp_pkg::WR_NONE;
		ctl.s_sel = ihp_pkg::S_KEEP;
		ctl.hold_sel = ihp_pkg::H_KEEP;
		ctl.child_sel = ihp_pkg::CH_KEEP;
		ctl.status = ihp_pkg::ST_OK;
		case (state_q)
			IDLE: begin
				ctl.in_ready = 1'b1;
				if (sts.accept) begin
					state_d = LOOK;
				end
			end
			LOOK: begin
				case (sts.cmd)
					ihp_pkg::CMD_INSERT: begin
						if (sts.present) begin
							ctl.set_status = 1'b1;
							ctl.status = ihp_pkg::ST_ABSENT;
							state_d = FIN;
						end else if (sts.full) begin
							ctl.set_status = 1'b1;
							ctl.status = ihp_pkg::ST_FULL;
							state_d = FIN;
						end else begin
							ctl.s_sel = ihp_pkg::S_COUNT;
							ctl.cnt_inc = 1'b1;
							ctl.hold_sel = ihp_pkg::H_REQ;
							need_down_d = 1'b0;
							state_d = UP_RD;
						end
					end
					ihp_pkg::CMD_CHANGE: begin
						if (!sts.present) begin
							ctl.set_status = 1'b1;
							ctl.status = ihp_pkg::ST_ABSENT;
							state_d = FIN;
						end else begin
							ctl.s_sel = ihp_pkg::S_MAP;
							state_d = CH_A;
						end
					end
					ihp_pkg::CMD_EXTRACT: begin
						if (sts.empty) begin
							ctl.set_status = 1'b1;
							ctl.status = ihp_pkg::ST_EMPTY;
							state_d = FIN;
						end else begin
							ctl.s_sel = ihp_pkg::S_ZERO;
							state_d = RM_A;
						end
					end
					default: begin
						if (!sts.present) begin
							ctl.set_status = 1'b1;
							ctl.status = ihp_pkg::ST_ABSENT;
							state_d = FIN;
						end else begin
							ctl.s_sel = ihp_pkg::S_MAP;
							state_d = RM_A;
						end
					end
				endcase
			end
			CH_A: begin
				ctl.rd_sel = ihp_pkg::RD_S;
				state_d = CH_B;
			end
			CH_B: begin
				if (sts.pri_eq) begin
					state_d = FIN;
				end else begin
					ctl.hold_sel = ihp_pkg::H_REQ;
					need_down_d = 1'b0;
					state_d = sts.pri_lt ? UP_RD : DN_RD;
				end
			end
			RM_A: begin
				ctl.rd_sel = ihp_pkg::RD_S;
				state_d = RM_B;
			end
			RM_B: begin
				ctl.capture_out = 1'b1;
				ctl.rd_sel = ihp_pkg::RD_LAST;
				ctl.cnt_dec = 1'b1;
				state_d = RM_C;
			end
			RM_C: begin
				if (sts.s_below) begin
					ctl.hold_sel = ihp_pkg::H_RD;
					ctl.mark_start = 1'b1;
					need_down_d = 1'b1;
					state_d = UP_RD;
				end else begin
					state_d = FIN;
				end
			end
			UP_RD: begin
				if (sts.s_zero) begin
					ctl.wr_sel = ihp_pkg::WR_HELD;
					state_d = down_after_up ? DN_RD : FIN;
				end else begin
					ctl.rd_sel = ihp_pkg::RD_PARENT;
					state_d = UP_CMP;
				end
			end
			UP_CMP: begin
				if (sts.parent_greater) begin
					ctl.wr_sel = ihp_pkg::WR_RD;
					ctl.s_sel = ihp_pkg::S_PARENT;
					state_d = UP_RD;
				end else begin
					ctl.wr_sel = ihp_pkg::WR_HELD;
					state_d = down_after_up ? DN_RD : FIN;
				end
			end
			DN_RD: begin
				if (!sts.l_in) begin
					ctl.wr_sel = ihp_pkg::WR_HELD;
					state_d = FIN;
				end else begin
					ctl.rd_sel = ihp_pkg::RD_LEFT;
					state_d = DN_RL;
				end
			end
			DN_RL: begin
				ctl.load_left = 1'b1;
				if (sts.r_in) begin
					ctl.rd_sel = ihp_pkg::RD_RIGHT;
					state_d = DN_RR;
				end else begin
					ctl.child_sel = ihp_pkg::CH_RD_LEFT;
					state_d = DN_CMP;
				end
			end
			DN_RR: begin
				ctl.child_sel = ihp_pkg::CH_PICK;
				state_d = DN_CMP;
			end
			DN_CMP: begin
				if (sts.child_less) begin
					ctl.wr_sel = ihp_pkg::WR_CHILD;
					ctl.s_sel = ihp_pkg::S_CHILD;
					state_d = DN_RD;
				end else begin
					ctl.wr_sel = ihp_pkg::WR_HELD;
					state_d = FIN;
				end
			end
			FIN: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			need_down_q <= 1'b0;
		end else begin
			state_q <= state_d;
			need_down_q <= need_down_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/ihp_dp.sv
// Datapath: heap and id map memories, sift registers and result register.
`default_nettype none
module ihp_dp #(
	parameter int CAPACITY = ihp_pkg::CapacityDefault,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int XW = AW + 2,
	localparam int OUT_W = ((ihp_pkg::IdW + ihp_pkg::PriW + ihp_pkg::StatW + CW + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ihp_pkg::ctl_t                ctl,
	output ihp_pkg::sts_t                sts,
	input  logic                         s_tvalid,
	input  logic [ihp_pkg::InDataW-1:0]  s_tdata,
	input  logic [ihp_pkg::CmdW-1:0]     s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [OUT_W-1:0]             m_tdata
);

	logic                       accept;
	ihp_pkg::cmd_t              cmd_q;
	logic [ihp_pkg::IdW-1:0]    id_q;
	logic [ihp_pkg::PriW-1:0]   pri_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              count_m1;
	logic [AW-1:0]              s_q, start_q, c_q, parent, last;
	ihp_pkg::entry_t            hold_q, left_q, child_q, rd_e, wr_e;
	logic [ihp_pkg::IdW-1:0]    rid_q;
	logic [ihp_pkg::PriW-1:0]   rpri_q;
	ihp_pkg::stat_t             rstat_q;
	logic [ihp_pkg::NumIds-1:0] valid_q;
	logic [ihp_pkg::EntryW-1:0] heap_rdata;
	logic [AW-1:0]              heap_raddr;
	logic                       heap_we;
	logic [AW-1:0]              map_rdata;
	logic [ihp_pkg::IdW-1:0]    map_raddr;
	logic [XW-1:0]              l_x, r_x, cnt_x;
	logic                       right_less;

	assign accept = s_tvalid && ctl.in_ready;
	assign rd_e = heap_rdata;
	assign parent = (s_q - AW'(1)) >> 1;
	assign count_m1 = count_q - CW'(1);
	assign last = count_m1[AW-1:0];
	assign l_x = {1'b0, s_q, 1'b1};
	assign r_x = l_x + XW'(1);
	assign cnt_x = XW'(count_q);
	assign right_less = rd_e.pri < left_q.pri;

	always_comb begin
		case (ctl.rd_sel)
			ihp_pkg::RD_PARENT: heap_raddr = parent;
			ihp_pkg::RD_LAST:   heap_raddr = last;
			ihp_pkg::RD_LEFT:   heap_raddr = l_x[AW-1:0];
			ihp_pkg::RD_RIGHT:  heap_raddr = r_x[AW-1:0];
			default:            heap_raddr = s_q;
		endcase
		case (ctl.wr_sel)
			ihp_pkg::WR_RD:    wr_e = rd_e;
			ihp_pkg::WR_CHILD: wr_e = child_q;
			default:           wr_e = hold_q;
		endcase
	end

	assign heap_we = ctl.wr_sel != ihp_pkg::WR_NONE;
	assign map_raddr = accept ? s_tdata[ihp_pkg::IdW-1:0] : id_q;

	ihp_ram #(.WIDTH(ihp_pkg::EntryW), .DEPTH(CAPACITY)) u_heap (
		.clk   (clk),
		.we    (heap_we),
		.waddr (s_q),
		.wdata (wr_e),
		.raddr (heap_raddr),
		.rdata (heap_rdata)
	);

	// Every heap write also records the entry's new slot in the id map.
	ihp_ram #(.WIDTH(AW), .DEPTH(ihp_pkg::NumIds)) u_map (
		.clk   (clk),
		.we    (heap_we),
		.waddr (wr_e.id),
		.wdata (s_q),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	always_comb begin
		sts.accept = accept;
		sts.cmd = cmd_q;
		sts.present = valid_q[id_q] && (XW'(map_rdata) < cnt_x);
		sts.full = count_q == CW'(CAPACITY);
		sts.empty = count_q == '0;
		sts.s_zero = s_q == '0;
		sts.parent_greater = rd_e.pri > hold_q.pri;
		sts.at_start = s_q == start_q;
		sts.s_below = XW'(s_q) < cnt_x;
		sts.l_in = l_x < cnt_x;
		sts.r_in = r_x < cnt_x;
		sts.child_less = child_q.pri < hold_q.pri;
		sts.pri_eq = pri_q == rd_e.pri;
		sts.pri_lt = pri_q < rd_e.pri;
		sts.out_free = !m_tvalid || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (ctl.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.cnt_dec) begin
				count_q <= count_m1;
			end
			if (heap_we) begin
				valid_q[wr_e.id] <= 1'b1;
			end else if (ctl.capture_out) begin
				valid_q[rd_e.id] <= 1'b0;
			end
			if (ctl.out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= ihp_pkg::cmd_t'(s_tuser);
			id_q <= s_tdata[ihp_pkg::IdW-1:0];
			pri_q <= s_tdata[ihp_pkg::IdW +: ihp_pkg::PriW];
			rid_q <= '0;
			rpri_q <= '0;
			rstat_q <= ihp_pkg::ST_OK;
		end
		if (ctl.set_status) begin
			rstat_q <= ctl.status;
		end
		if (ctl.capture_out) begin
			rid_q <= rd_e.id;
			rpri_q <= rd_e.pri;
		end
		case (ctl.s_sel)
			ihp_pkg::S_COUNT:  s_q <= count_q[AW-1:0];
			ihp_pkg::S_ZERO:   s_q <= '0;
			ihp_pkg::S_MAP:    s_q <= map_rdata;
			ihp_pkg::S_PARENT: s_q <= parent;
			ihp_pkg::S_CHILD:  s_q <= c_q;
			default:           s_q <= s_q;
		endcase
		case (ctl.hold_sel)
			ihp_pkg::H_REQ: hold_q <= {pri_q, id_q};
			ihp_pkg::H_RD:  hold_q <= rd_e;
			default:        hold_q <= hold_q;
		endcase
		if (ctl.mark_start) begin
			start_q <= s_q;
		end
		if (ctl.load_left) begin
			left_q <= rd_e;
		end
		// The left child wins ties.
		case (ctl.child_sel)
			ihp_pkg::CH_RD_LEFT: begin
				child_q <= rd_e;
				c_q <= l_x[AW-1:0];
			end
			ihp_pkg::CH_PICK: begin
				child_q <= right_less ? rd_e : left_q;
				c_q <= right_less ? r_x[AW-1:0] : l_x[AW-1:0];
			end
			default: begin
				child_q <= child_q;
			end
		endcase
		if (ctl.out_load) begin
			m_tdata <= OUT_W'({count_q, rstat_q, rpri_q, rid_q});
		end
	end

endmodule
`default_nettype wire

// File: rtl/indexed_min_heap_top.sv
// Top level of the indexed min-heap priority queue.
// Indexed binary min-heap of item ids 0..255 keyed by 16-bit priority, with a map from id to
// heap slot. s_tuser selects insert, change priority, extract minimum or delete; each item
// gives one result item. Items are handled one at a time through a single read port of the
// heap memory: lookup and setup, then sift-up levels of a parent read and a compare, and
// sift-down levels of up to two child reads, a compare and a move; a rejected request
// goes from lookup straight to the result. A new item is taken while the previous result
// still waits on the output.
`default_nettype none
module indexed_min_heap_top #(
	parameter int CAPACITY = ihp_pkg::CapacityDefault,
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int OUT_W = ((ihp_pkg::IdW + ihp_pkg::PriW + ihp_pkg::StatW + CW + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [ihp_pkg::InDataW-1:0] s_tdata,  // item_id, priority_req
	input  logic [ihp_pkg::CmdW-1:0]    s_tuser,  // cmd
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [OUT_W-1:0]            m_tdata   // out_id, out_priority, status, count
);

	ihp_pkg::ctl_t ctl;
	ihp_pkg::sts_t sts;

	assign s_tready = ctl.in_ready;

	ihp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	ihp_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the indexed min-heap priority queue.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import ihp_pkg::*;

	localparam int Cap = 256;
	localparam int CntW = $clog2(Cap + 1);
	localparam int OutW = ((IdW + PriW + StatW + CntW + 7) / 8) * 8;
	localparam int RandItems = 1200;
	localparam longint CycleLimit = 2000000;

	typedef struct packed {
		logic [IdW-1:0]   id;
		logic [PriW-1:0]  pri;
		stat_t            st;
		logic [CntW-1:0]  cnt;
	} heap_result_t;

	// Predictor of the heap plus the queue of results it expects.
	class heap_scoreboard;
		logic [PriW-1:0] pri_of[Cap];
		logic [IdW-1:0]  id_of[Cap];
		int              pos_of[NumIds];
		int              fill;
		heap_result_t    pending[$];
		int              errors;

		function void clear();
			for (int i = 0; i < NumIds; i++) pos_of[i] = Cap;
			for (int i = 0; i < Cap; i++) begin
				pri_of[i] = '0;
				id_of[i] = '0;
			end
			fill = 0;
			errors = 0;
		endfunction

		function void put(int s, logic [IdW-1:0] id, logic [PriW-1:0] p);
			id_of[s] = id;
			pri_of[s] = p;
			pos_of[id] = s;
		endfunction

		function void rise(int s);
			logic [IdW-1:0] id;
			logic [PriW-1:0] k;
			int p;
			id = id_of[s];
			k = pri_of[s];
			while (s > 0) begin
				p = (s - 1) / 2;
				if (pri_of[p] <= k) break;
				put(s, id_of[p], pri_of[p]);
				s = p;
			end
			put(s, id, k);
		endfunction

		function void sink(int s);
			logic [IdW-1:0] id;
			logic [PriW-1:0] k;
			int l, c;
			id = id_of[s];
			k = pri_of[s];
			forever begin
				l = 2 * s + 1;
				if (l >= fill) break;
				c = l;
				if (l + 1 < fill && pri_of[l + 1] < pri_of[l]) c = l + 1;
				if (!(pri_of[c] < k)) break;
				put(s, id_of[c], pri_of[c]);
				s = c;
			end
			put(s, id, k);
		endfunction

		function void take_slot(int s);
			int last;
			last = fill - 1;
			pos_of[id_of[s]] = Cap;
			fill = last;
			if (s < last) begin
				put(s, id_of[last], pri_of[last]);
				rise(s);
				sink(pos_of[id_of[s]] == s ? s : pos_of[id_of[s]]);
			end
		endfunction

		function bit has(logic [IdW-1:0] id);
			return pos_of[id] < fill;
		endfunction

		function void note_request(cmd_t c, logic [IdW-1:0] id, logic [PriW-1:0] p);
			heap_result_t r;
			int s;
			r = '0;
			r.st = ST_OK;
			case (c)
				CMD_INSERT: begin
					if (has(id)) r.st = ST_ABSENT;
					else if (fill >= Cap) r.st = ST_FULL;
					else begin
						fill++;
						put(fill - 1, id, p);
						rise(fill - 1);
					end
				end
				CMD_CHANGE: begin
					if (!has(id)) r.st = ST_ABSENT;
					else begin
						s = pos_of[id];
						if (p != pri_of[s]) begin
							if (p < pri_of[s]) begin
								pri_of[s] = p;
								rise(s);
							end else begin
								pri_of[s] = p;
								sink(s);
							end
						end
					end
				end
				CMD_EXTRACT: begin
					if (fill == 0) r.st = ST_EMPTY;
					else begin
						r.id = id_of[0];
						r.pri = pri_of[0];
						take_slot(0);
					end
				end
				default: begin
					if (!has(id)) r.st = ST_ABSENT;
					else begin
						s = pos_of[id];
						r.id = id_of[s];
						r.pri = pri_of[s];
						take_slot(s);
					end
				end
			endcase
			r.cnt = fill[CntW-1:0];
			pending.push_back(r);
		endfunction

		function void check_result(logic [OutW-1:0] d);
			heap_result_t want, got;
			got.id = d[IdW-1:0];
			got.pri = d[IdW +: PriW];
			got.st = stat_t'(d[IdW+PriW +: StatW]);
			got.cnt = d[IdW+PriW+StatW +: CntW];
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result id=%0d pri=%0d st=%0d cnt=%0d",
					got.id, got.pri, got.st, got.cnt);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: exp id=%0d pri=%0d st=%0d cnt=%0d, ",
						"got id=%0d pri=%0d st=%0d cnt=%0d"},
						want.id, want.pri, want.st, want.cnt,
						got.id, got.pri, got.st, got.cnt);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [InDataW-1:0] s_tdata = '0;
	logic [CmdW-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OutW-1:0] m_tdata;

	heap_scoreboard heap_model;
	longint cycles = 0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;

	indexed_min_heap_top #(.CAPACITY(Cap)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Offers one request and waits for its acceptance; the model is updated on acceptance.
	// The valid stays high between back-to-back items and drops only for a gap.
	task automatic send_request(cmd_t c, logic [IdW-1:0] id, logic [PriW-1:0] p, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= {p, id};
		do @(posedge clk); while (!s_tready);
		heap_model.note_request(c, id, p);
	endtask

	// Random request; most non-insert requests are aimed at ids currently in the heap so sifts go deep.
	task automatic send_random(int stage);
		cmd_t c;
		logic [IdW-1:0] id;
		logic [PriW-1:0] p;
		int r;
		r = $urandom_range(0, 99);
		if (stage == 0)
			c = r < 70 ? CMD_INSERT : r < 85 ? CMD_CHANGE : r < 93 ? CMD_DELETE : CMD_EXTRACT;
		else if (stage == 1)
			c = r < 30 ? CMD_INSERT : r < 55 ? CMD_CHANGE : r < 75 ? CMD_DELETE : CMD_EXTRACT;
		else
			c = r < 10 ? CMD_INSERT : r < 30 ? CMD_CHANGE : r < 50 ? CMD_DELETE : CMD_EXTRACT;
		id = IdW'($urandom);
		if (c != CMD_INSERT && heap_model.fill > 0 && $urandom_range(0, 9) < 8) begin
			r = $urandom_range(0, heap_model.fill - 1);
			id = heap_model.id_of[r];
		end
		r = $urandom_range(0, 9);
		p = r < 3 ? PriW'($urandom_range(0, 15)) : r < 4 ? '1 : PriW'($urandom);
		send_request(c, id, p, 1'b1);
	endtask

	initial begin
		heap_model = new();
		heap_model.clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// Directed: empty extract, absent change/delete, extremes, duplicates and ties.
		send_request(CMD_EXTRACT, 8'd0, 16'd0, 1'b0);
		send_request(CMD_CHANGE, 8'd5, 16'd1, 1'b0);
		send_request(CMD_DELETE, 8'd5, 16'd0, 1'b0);
		send_request(CMD_INSERT, 8'd255, 16'hFFFF, 1'b0);
		send_request(CMD_INSERT, 8'd0, 16'd0, 1'b0);
		send_request(CMD_INSERT, 8'd0, 16'd7, 1'b0);
		send_request(CMD_INSERT, 8'd17, 16'd0, 1'b0);
		send_request(CMD_INSERT, 8'd170, 16'h5555, 1'b0);
		send_request(CMD_INSERT, 8'd85, 16'hAAAA, 1'b0);
		send_request(CMD_CHANGE, 8'd85, 16'hAAAA, 1'b0);
		send_request(CMD_CHANGE, 8'd255, 16'd0, 1'b0);
		send_request(CMD_CHANGE, 8'd0, 16'hFFFF, 1'b0);
		send_request(CMD_DELETE, 8'd170, 16'd0, 1'b0);
		send_request(CMD_EXTRACT, 8'd0, 16'd0, 1'b0);
		send_request(CMD_EXTRACT, 8'd0, 16'd0, 1'b0);
		send_request(CMD_DELETE, 8'd255, 16'd0, 1'b0);
		// Fill to capacity, then duplicates on the full heap and a delete and reinsert.
		for (int i = 0; i < Cap; i++)
			if (!heap_model.has(i[IdW-1:0]))
				send_request(CMD_INSERT, i[IdW-1:0], PriW'($urandom_range(0, 3) * 1000), 1'b1);
		send_request(CMD_INSERT, 8'd3, 16'd1, 1'b0);
		send_request(CMD_DELETE, 8'd200, 16'd0, 1'b0);
		send_request(CMD_INSERT, 8'd201, 16'd9, 1'b0);
		send_request(CMD_INSERT, 8'd200, 16'd9, 1'b0);
		send_request(CMD_INSERT, 8'd201, 16'd9, 1'b0);
		// Drain with a long receiver stall so the block backs up.
		hold_off = 1'b1;
		for (int i = 0; i < 40; i++) send_request(CMD_EXTRACT, 8'd0, 16'd0, 1'b0);
		hold_off = 1'b0;
		for (int i = 0; i < RandItems; i++)
			send_random(i < 300 ? 0 : i < 850 ? 1 : (i < 1100 ? 2 : 1));
		while (heap_model.fill > 0) send_request(CMD_EXTRACT, 8'd0, 16'd0, 1'b1);
		send_request(CMD_EXTRACT, 8'd0, 16'd0, 1'b0);
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: random stalls, plus a long counted hold-off when requested.
	initial begin
		int g;
		int held;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_tready <= 1'b0;
				for (held = 0; held < 3000; held++) @(posedge clk);
				m_tready <= 1'b1;
				@(posedge clk);
				while (hold_off) @(posedge clk);
			end else begin
				g = gap_len();
				if (g > 0) begin
					m_tready <= 1'b0;
					repeat (g) @(posedge clk);
				end
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) heap_model.check_result(m_tdata);

	initial begin
		wait (stim_done);
		while (heap_model.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (heap_model.errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end
endmodule
`default_nettype wire
